// ===== rtl/core/lfwt_pkg.sv =====
// ----------------------------------------------------------------------------
// lfwt_pkg
// Shared constants, types and helpers for the line framer with trim.
// ----------------------------------------------------------------------------
`default_nettype none

package lfwt_pkg;

   localparam int MAX_LINE   = 4096;
   localparam int PEND_DEPTH = 32;

   localparam int PEND_AW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
   localparam int CNT_W   = $clog2(PEND_DEPTH + 1);
   localparam int LEN_W   = 13;
   localparam int LEN_MAX = (1 << LEN_W) - 1;

   localparam logic [LEN_W-1:0] LEN_CAP =
      LEN_W'((MAX_LINE > LEN_MAX) ? LEN_MAX : MAX_LINE);

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_VT  = 8'h0B;
   localparam logic [7:0] CHAR_FF  = 8'h0C;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_SP  = 8'h20;

   typedef enum logic {
      ST_IDLE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic is_swallow;
      logic is_term;
      logic is_blank;
      logic text_seen;
      logic pend_empty;
      logic pend_full;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic accept;
      logic emit_end;
      logic emit_in;
      logic emit_head;
      logic emit_held;
      logic push_in;
      logic pop_head;
      logic load_held;
      logic clear_line;
      logic set_text;
   } cmd_type;

   function automatic logic is_blank(input logic [7:0] b);
      is_blank = (b == CHAR_SP) || (b == CHAR_TAB) || (b == CHAR_VT) || (b == CHAR_FF);
   endfunction

   function automatic logic is_term(input logic [7:0] b);
      is_term = (b == CHAR_CR) || (b == CHAR_LF) || (b == CHAR_NUL);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/line_framer_with_trim.sv =====
// ----------------------------------------------------------------------------
// line_framer_with_trim
// Splits a byte stream into lines, drops leading whitespace and the trailing
// whitespace still pending, and marks each line end with the stripped length.
// ----------------------------------------------------------------------------
// A byte other than a text byte behind held whitespace is accepted whenever the
// result register is free. A text byte that follows held whitespace bytes is
// accepted first; the held bytes then leave the pending queue one per cycle,
// while the receiver does not stall, through the single result register, and
// the text byte itself follows them. No new byte is taken until then. Line ends are
// CR, LF, NUL, CR LF and CR NUL; the result for a line end carries the stripped
// length, saturating at the package line limit.
`default_nettype none

module line_framer_with_trim (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_in_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_line_end,
   output logic [lfwt_pkg::LEN_W-1:0]     rsp_line_length
);

   lfwt_pkg::status_type status;
   lfwt_pkg::cmd_type    cmd;

   lfwt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lfwt_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_line_end    (rsp_line_end),
      .rsp_line_length (rsp_line_length),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

`default_nettype wire

// ===== rtl/core/lfwt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfwt_ctrl
// Controller: classifies each accepted byte into datapath commands and
// sequences the release of pending whitespace ahead of a text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lfwt_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire lfwt_pkg::status_type status,
   output lfwt_pkg::cmd_type       cmd
);

   lfwt_pkg::state_type state_ff, state_in;
   logic                accept;

   assign req_stall = (state_ff == lfwt_pkg::ST_IDLE) ? !status.out_free : 1'b1;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfwt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lfwt_pkg::ST_IDLE: begin
            if (accept && !status.is_swallow && !status.is_term && !status.is_blank &&
                !status.pend_empty) begin
               state_in = lfwt_pkg::ST_FLUSH;
            end
         end
         lfwt_pkg::ST_FLUSH: begin
            if (status.out_free && status.pend_empty) begin
               state_in = lfwt_pkg::ST_IDLE;
            end
         end
         default: state_in = lfwt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         lfwt_pkg::ST_IDLE: begin
            cmd.accept = accept;
            if (accept && !status.is_swallow) begin
               if (status.is_term) begin
                  cmd.emit_end   = 1'b1;
                  cmd.clear_line = 1'b1;
               end else if (status.is_blank) begin
                  if (status.text_seen) begin
                     cmd.push_in = 1'b1;
                     if (status.pend_full) begin
                        cmd.emit_head = 1'b1;
                        cmd.pop_head  = 1'b1;
                     end
                  end
               end else begin
                  cmd.set_text = 1'b1;
                  if (status.pend_empty) begin
                     cmd.emit_in = 1'b1;
                  end else begin
                     cmd.load_held = 1'b1;
                  end
               end
            end
         end
         lfwt_pkg::ST_FLUSH: begin
            if (status.out_free) begin
               if (!status.pend_empty) begin
                  cmd.emit_head = 1'b1;
                  cmd.pop_head  = 1'b1;
               end else begin
                  cmd.emit_held = 1'b1;
               end
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/lfwt_dpath.sv =====
// ----------------------------------------------------------------------------
// lfwt_dpath
// Datapath: line state, pending whitespace queue, length counter and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfwt_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [7:0]                    req_in_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_line_end,
   output logic [lfwt_pkg::LEN_W-1:0]         rsp_line_length,
   input  wire lfwt_pkg::cmd_type             cmd,
   output lfwt_pkg::status_type               status
);

   logic                           after_cr_ff;
   logic                           text_seen_ff, text_seen_in;
   logic [7:0]                     pend_ff [lfwt_pkg::PEND_DEPTH];
   logic [lfwt_pkg::PEND_AW-1:0]   head_ff, head_in;
   logic [lfwt_pkg::PEND_AW-1:0]   tail_ff, tail_in;
   logic [lfwt_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [lfwt_pkg::LEN_W-1:0]     kept_ff, kept_in;
   logic [7:0]                     held_ff;
   logic                           out_valid_ff, out_valid_in;
   logic [7:0]                     out_byte_ff, out_byte_in;
   logic                           out_end_ff, out_end_in;
   logic [lfwt_pkg::LEN_W-1:0]     out_len_ff, out_len_in;
   logic [7:0]                     head_byte;
   logic                           emit_data;

   function automatic logic [lfwt_pkg::PEND_AW-1:0] ptr_next(
      input logic [lfwt_pkg::PEND_AW-1:0] p);
      if (p == lfwt_pkg::PEND_AW'(lfwt_pkg::PEND_DEPTH - 1)) begin
         ptr_next = '0;
      end else begin
         ptr_next = p + lfwt_pkg::PEND_AW'(1);
      end
   endfunction

   assign head_byte = pend_ff[head_ff];
   assign emit_data = cmd.emit_in || cmd.emit_head || cmd.emit_held;

   always_comb begin
      status.is_swallow = after_cr_ff &&
                          ((req_in_byte == lfwt_pkg::CHAR_LF) ||
                           (req_in_byte == lfwt_pkg::CHAR_NUL));
      status.is_term    = lfwt_pkg::is_term(req_in_byte);
      status.is_blank   = lfwt_pkg::is_blank(req_in_byte);
      status.text_seen  = text_seen_ff;
      status.pend_empty = (count_ff == '0);
      status.pend_full  = (count_ff == lfwt_pkg::CNT_W'(lfwt_pkg::PEND_DEPTH));
      status.out_free   = !out_valid_ff || !rsp_stall;
   end

   always_comb begin
      text_seen_in = text_seen_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      kept_in      = kept_ff;
      if (cmd.set_text) begin
         text_seen_in = 1'b1;
      end
      if (cmd.push_in) begin
         tail_in = ptr_next(tail_ff);
      end
      if (cmd.pop_head) begin
         head_in = ptr_next(head_ff);
      end
      if (cmd.push_in && !cmd.pop_head) begin
         count_in = count_ff + lfwt_pkg::CNT_W'(1);
      end else if (cmd.pop_head && !cmd.push_in) begin
         count_in = count_ff - lfwt_pkg::CNT_W'(1);
      end
      if (emit_data && (kept_ff < lfwt_pkg::LEN_CAP)) begin
         kept_in = kept_ff + lfwt_pkg::LEN_W'(1);
      end
      if (cmd.clear_line) begin
         text_seen_in = 1'b0;
         head_in      = '0;
         tail_in      = '0;
         count_in     = '0;
         kept_in      = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      out_len_in   = out_len_ff;
      if (cmd.emit_end) begin
         out_valid_in = 1'b1;
         out_byte_in  = '0;
         out_end_in   = 1'b1;
         out_len_in   = kept_ff;
      end else if (emit_data) begin
         out_valid_in = 1'b1;
         out_end_in   = 1'b0;
         out_len_in   = '0;
         if (cmd.emit_head) begin
            out_byte_in = head_byte;
         end else if (cmd.emit_held) begin
            out_byte_in = held_ff;
         end else begin
            out_byte_in = req_in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_cr_ff  <= 1'b0;
         text_seen_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         kept_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            after_cr_ff <= (req_in_byte == lfwt_pkg::CHAR_CR);
         end
         text_seen_ff <= text_seen_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         kept_ff      <= kept_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_in) begin
         pend_ff[tail_ff] <= req_in_byte;
      end
      if (cmd.load_held) begin
         held_ff <= req_in_byte;
      end
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
      out_len_ff  <= out_len_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_line_end    = out_end_ff;
   assign rsp_line_length = out_len_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lfwt_checker.sv =====
// ----------------------------------------------------------------------------
// lfwt_checker
// Port-level checks for the line framer with trim, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfwt_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic [7:0]                req_in_byte,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic [7:0]                rsp_out_byte,
   input wire logic                      rsp_line_end,
   input wire logic [lfwt_pkg::LEN_W-1:0] rsp_line_length
);

   a_end_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_end |-> rsp_out_byte == 8'h00)
      else $error("line end transaction carries a nonzero byte");

   a_data_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_end |-> rsp_line_length == '0)
      else $error("data transaction carries a nonzero length");

   a_len_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_length <= lfwt_pkg::LEN_CAP)
      else $error("line length above its cap");

   a_term_no_stall_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_in_byte == lfwt_pkg::CHAR_CR |=>
         rsp_valid && rsp_line_end)
      else $error("CR did not produce a line end");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_line_end) && $stable(rsp_line_length))
      else $error("stalled result transaction changed");

endmodule

bind line_framer_with_trim lfwt_checker u_lfwt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_in_byte     (req_in_byte),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_line_end    (rsp_line_end),
   .rsp_line_length (rsp_line_length)
);

`default_nettype wire
